[hw/rtl/bpff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpff_pkg
// Shared types and constants for the buffer pool first-fit cache: request and
// result words, the entry word and the entry memory write port.
// ----------------------------------------------------------------------------
package bpff_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_DEPTH = MAX_ENTRIES + 1;
    localparam int CNT_W       = 5;
    localparam int HANDLE_W    = 16;
    localparam int LENGTH_W    = 32;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                func;
        logic [LENGTH_W-1:0] request_size;
        logic [HANDLE_W-1:0] buffer_handle;
        logic [LENGTH_W-1:0] buffer_length;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found_handle;
        logic [LENGTH_W-1:0] found_length;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
        logic [CNT_W-1:0]    entry_count;
    } t_res;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

endpackage

[hw/rtl/buffer_pool_first_fit_cache_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_first_fit_cache_unit
// Ordered buffer cache, newest first: get takes the first entry long enough,
// put inserts at the front and evicts the oldest entry past capacity.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// word appears on o_res for one cycle with o_done, and must be taken then.
// The entries live in a single-port-write memory and a sequencer moves one
// entry per cycle through one length comparator. A get on an empty row
// answers a miss straight from idle; a get scans from the front and, on a
// hit before the last entry, closes the gap behind the entry it took; a put
// shifts every entry back by one and then inserts at the front. The result
// word is registered after the last step, and busy drops in the cycle that
// it appears. Capacity writes are taken at any time while idle.
// ----------------------------------------------------------------------------
module buffer_pool_first_fit_cache_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bpff_pkg::t_req              i_req,
    output logic                        o_done,
    output bpff_pkg::t_res              o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bpff_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam logic [bpff_pkg::CNT_W-1:0] CntMax = bpff_pkg::CNT_W'(bpff_pkg::MAX_ENTRIES);
    localparam logic [bpff_pkg::CNT_W-1:0] One    = bpff_pkg::CNT_W'(1);
    localparam logic [bpff_pkg::CNT_W-1:0] Two    = bpff_pkg::CNT_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GSHIFT,
        S_PSHIFT,
        S_PINS
    } t_state;

    t_state                         r_state;
    logic [bpff_pkg::CNT_W-1:0]     r_cnt;
    logic [bpff_pkg::CNT_W-1:0]     r_cap;
    logic [bpff_pkg::CNT_W-1:0]     r_idx;
    bpff_pkg::t_req                 r_req;
    bpff_pkg::t_entry               r_found;
    logic [bpff_pkg::HANDLE_W-1:0]  r_ev_handle;
    logic                           r_done;
    bpff_pkg::t_res                 r_res;

    bpff_pkg::t_mem_wr              mem_wr;
    logic [bpff_pkg::CNT_W-1:0]     rd_addr;
    bpff_pkg::t_entry               rd_data;

    logic [bpff_pkg::CNT_W-1:0]     cap_eff;
    logic                           fits;
    logic                           scan_last;
    logic                           gshift_last;
    logic                           fin_valid;
    bpff_pkg::t_res                 fin_res;

    bpff_entry_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_res       = r_res;

    assign cap_eff     = (r_cap > CntMax) ? CntMax : r_cap;
    assign fits        = (rd_data.length >= r_req.request_size);
    assign scan_last   = (r_idx == r_cnt - One);
    assign gshift_last = (r_idx + Two == r_cnt);

    // read address for the next cycle's entry
    always_comb begin
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.func == bpff_pkg::FUNC_PUT && r_cnt != '0) begin
                    rd_addr = r_cnt - One;
                end
            end
            S_SCAN:   rd_addr = r_idx + One;
            S_GSHIFT: rd_addr = r_idx + Two;
            S_PSHIFT: begin
                if (r_idx >= Two) begin
                    rd_addr = r_idx - Two;
                end
            end
            S_PINS:   rd_addr = '0;
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        mem_wr.en   = 1'b0;
        mem_wr.addr = r_idx;
        mem_wr.data = rd_data;
        unique case (r_state)
            S_GSHIFT, S_PSHIFT: begin
                mem_wr.en = 1'b1;
            end
            S_PINS: begin
                mem_wr.en          = 1'b1;
                mem_wr.addr        = '0;
                mem_wr.data.handle = r_req.buffer_handle;
                mem_wr.data.length = r_req.buffer_length;
            end
            default: begin
                mem_wr.en = 1'b0;
            end
        endcase
    end

    // result word of the finishing step
    always_comb begin
        fin_valid           = 1'b0;
        fin_res             = '0;
        fin_res.entry_count = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                fin_valid = start && (i_req.func == bpff_pkg::FUNC_GET) && (r_cnt == '0);
            end
            S_SCAN: begin
                if (scan_last) begin
                    fin_valid = 1'b1;
                    if (fits) begin
                        fin_res.hit          = 1'b1;
                        fin_res.found_handle = rd_data.handle;
                        fin_res.found_length = rd_data.length;
                        fin_res.entry_count  = r_cnt - One;
                    end
                end
            end
            S_GSHIFT: begin
                if (gshift_last) begin
                    fin_valid            = 1'b1;
                    fin_res.hit          = 1'b1;
                    fin_res.found_handle = r_found.handle;
                    fin_res.found_length = r_found.length;
                    fin_res.entry_count  = r_cnt - One;
                end
            end
            S_PINS: begin
                fin_valid = 1'b1;
                if (r_cnt + One > cap_eff) begin
                    fin_res.evicted        = 1'b1;
                    fin_res.evicted_handle = (r_cnt == '0) ? r_req.buffer_handle
                                                           : r_ev_handle;
                end else begin
                    fin_res.entry_count = r_cnt + One;
                end
            end
            default: begin
                fin_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cap   <= CntMax;
            r_done  <= 1'b0;
        end else begin
            r_done <= fin_valid;
            if (fin_valid) begin
                r_res <= fin_res;
                r_cnt <= fin_res.entry_count;
            end
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_req;
                        if (i_req.func == bpff_pkg::FUNC_PUT) begin
                            r_idx   <= r_cnt;
                            r_state <= (r_cnt == '0) ? S_PINS : S_PSHIFT;
                        end else begin
                            r_idx   <= '0;
                            r_state <= (r_cnt == '0) ? S_IDLE : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (fits) begin
                        r_found <= rd_data;
                        // read of the next entry is already out: close the gap
                        r_state <= scan_last ? S_IDLE : S_GSHIFT;
                    end else if (scan_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + One;
                    end
                end
                S_GSHIFT: begin
                    if (gshift_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + One;
                    end
                end
                S_PSHIFT: begin
                    // first word moved is the oldest entry: hold it for eviction
                    if (r_idx == r_cnt) begin
                        r_ev_handle <= rd_data.handle;
                    end
                    if (r_idx == One) begin
                        r_state <= S_PINS;
                    end else begin
                        r_idx <= r_idx - One;
                    end
                end
                S_PINS: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/bpff_entry_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpff_entry_mem
// Entry row storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpff_entry_mem (
    input  logic                        i_clk,
    input  bpff_pkg::t_mem_wr           i_wr,
    input  logic [bpff_pkg::CNT_W-1:0]  i_rd_addr,
    output bpff_pkg::t_entry            o_rd_data
);

    bpff_pkg::t_entry r_mem [bpff_pkg::ENTRY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
